>>> rtl/bed_pkg.sv
// Package for the button event detector: state and event codes, register
// indexes, field widths and saturation limits. No dependencies.
`timescale 1ns / 1ps

package bed_pkg;

    // Pin field and effective pin width of the sampled port
    localparam int unsigned PIN_W      = 8;
    localparam int unsigned C_PIN_BITS = 8;
    localparam logic [PIN_W-1:0] C_PIN_MASK =
        (C_PIN_BITS >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << C_PIN_BITS) - 1);

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned DIV_W   = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 16;

    localparam logic [TIME_W-1:0] C_TIME_SAT  = TIME_W'(60000);
    localparam logic [TIME_W-1:0] C_COUNT_SAT = TIME_W'(65535);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] C_REG_VALUE_MASK   = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] C_REG_ACTIVE_VALUE = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] C_REG_STEP_PERIOD  = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] C_REG_LONG_PRESS   = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] C_REG_LONG_REPEAT  = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] C_REG_MULTI_BREAK  = CFG_AW'(5);

    typedef enum logic [STATE_W-1:0] {
        ST_RELEASED    = 3'd0,
        ST_FIRST_PRESS = 3'd1,
        ST_LONG        = 3'd2,
        ST_FIRST_UP    = 3'd3,
        ST_MULTI       = 3'd4
    } t_state;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE        = 3'd0,
        EV_PRESS       = 3'd1,
        EV_UP          = 3'd2,
        EV_LONG_PRESS  = 3'd3,
        EV_LONG_UP     = 3'd4,
        EV_MULTI_PRESS = 3'd5,
        EV_MULTI_UP    = 3'd6
    } t_event;

    // Per-tick status handed from the tick counters to the machine
    typedef struct packed {
        logic              step;          // a tick is transferred this cycle
        logic              run;           // machine evaluates on this tick
        logic              pressed;
        logic              changed;       // masked value differs from last tick
        logic [TIME_W-1:0] pressed_time;  // already updated for this tick
        logic [TIME_W-1:0] released_time;
    } t_tick;

    typedef struct packed {
        logic [TIME_W-1:0] long_press;
        logic [TIME_W-1:0] long_repeat;
        logic [TIME_W-1:0] multi_break;
    } t_thresh;

    typedef struct packed {
        t_event            code;
        logic [TIME_W-1:0] arg;
        t_state            state;
    } t_result;

endpackage

>>> rtl/bed_fsm.sv
// Five-state press machine of the button event detector: state, press
// count, repeat mark and toggle flag. Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_fsm
    import bed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_tick   i_tick,
    input  t_thresh i_thresh,
    output t_result o_result
);

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_press_count, n_press_count;
    logic [TIME_W-1:0] r_last_repeat, n_last_repeat;
    logic              r_toggle, n_toggle;

    logic              toggle_now;
    logic [TIME_W-1:0] repeat_diff;
    t_event            ev_code;
    logic [TIME_W-1:0] ev_arg;

    // Flag seen by the machine includes this tick's change
    assign toggle_now  = r_toggle | i_tick.changed;
    assign repeat_diff = (i_tick.pressed_time >= r_last_repeat)
                       ? i_tick.pressed_time - r_last_repeat
                       : r_last_repeat - i_tick.pressed_time;

    // Next state and event for one tick
    always_comb begin
        n_state       = r_state;
        n_press_count = r_press_count;
        n_last_repeat = r_last_repeat;
        n_toggle      = toggle_now;
        ev_code       = EV_NONE;
        ev_arg        = '0;
        if (i_tick.run) begin
            unique case (r_state)
                ST_RELEASED: begin
                    if (i_tick.pressed) begin
                        n_state = ST_FIRST_PRESS;
                        ev_code = EV_PRESS;
                    end
                end
                ST_FIRST_PRESS: begin
                    if (!i_tick.pressed) begin
                        n_state = ST_FIRST_UP;
                        ev_code = EV_UP;
                    end else if (i_tick.pressed_time >= i_thresh.long_press) begin
                        n_state       = ST_LONG;
                        n_last_repeat = '0;
                    end
                end
                ST_LONG: begin
                    if (!i_tick.pressed) begin
                        n_state = ST_RELEASED;
                        ev_code = EV_LONG_UP;
                    end else if (repeat_diff >= i_thresh.long_repeat) begin
                        n_last_repeat = i_tick.pressed_time;
                        ev_code       = EV_LONG_PRESS;
                        ev_arg        = i_tick.pressed_time;
                    end
                end
                ST_FIRST_UP: begin
                    if (i_tick.pressed) begin
                        n_state       = ST_MULTI;
                        n_press_count = TIME_W'(1);
                    end else if (i_tick.released_time >= i_thresh.multi_break) begin
                        n_state = ST_RELEASED;
                    end
                end
                ST_MULTI: begin
                    if (toggle_now) begin
                        n_toggle = 1'b0;
                        if (i_tick.pressed) begin
                            if (r_press_count < C_COUNT_SAT) begin
                                n_press_count = r_press_count + TIME_W'(1);
                            end
                            ev_code = EV_MULTI_PRESS;
                        end else begin
                            ev_code = EV_MULTI_UP;
                        end
                        ev_arg = n_press_count;
                    end else if (i_tick.pressed_time >= i_thresh.long_press) begin
                        n_state       = ST_LONG;
                        n_last_repeat = '0;
                    end else if (i_tick.released_time >= i_thresh.multi_break) begin
                        n_state = ST_RELEASED;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    assign o_result.code  = ev_code;
    assign o_result.arg   = ev_arg;
    assign o_result.state = n_state;

    // Advance machine state on each transferred tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RELEASED;
            r_press_count <= '0;
            r_last_repeat <= '0;
            r_toggle      <= 1'b0;
        end else if (i_tick.step) begin
            r_state       <= n_state;
            r_press_count <= n_press_count;
            r_last_repeat <= n_last_repeat;
            r_toggle      <= n_toggle;
        end
    end

endmodule

>>> rtl/button_event_detector.sv
// Top level of the button event detector: configuration registers, tick
// counters and the output skid stage. Depends on bed_pkg and bed_fsm.
`timescale 1ns / 1ps

// One input transfer is one 1 ms tick of raw pin bits; every tick gives
// exactly one result transfer (event code, argument and machine state after
// the tick). A tick is taken every clock cycle while input ready is high:
// the counters and the press machine update in the cycle of the input
// transfer and the result lands in a two-entry output stage (result register
// plus skid register), so input ready drops only when both entries hold
// results not yet taken. Configuration writes take effect on the next edge
// and are meant to happen while no tick is in flight.
module button_event_detector
    import bed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    // Tick input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] pin_value
    // Event output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata    // [2:0] event_code, [18:3] event_arg,
                                              // [21:19] button_state, [23:22] zero
);

    // Configuration registers
    logic [PIN_W-1:0]  r_value_mask, r_active_value;
    logic [DIV_W-1:0]  r_step_period;
    logic [TIME_W-1:0] r_long_press, r_long_repeat, r_multi_break;

    // Tick state
    logic [TIME_W-1:0] r_pressed_time, n_pressed_time;
    logic [TIME_W-1:0] r_released_time, n_released_time;
    logic [PIN_W-1:0]  r_prev_value;
    logic [DIV_W-1:0]  r_divider, n_divider;

    // Output stage
    logic              r_out_valid, r_skd_valid;
    t_result           r_out_data, r_skd_data;

    logic              accept, pop;
    logic [PIN_W-1:0]  masked_value;
    logic              pressed;
    logic [DIV_W-1:0]  div_inc;
    t_tick             tick;
    t_thresh           thresh;
    t_result           result;

    assign accept = s_axis_tvalid & s_axis_tready;
    assign pop    = r_out_valid & m_axis_tready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_mask   <= PIN_W'(1);
            r_active_value <= '0;
            r_step_period  <= DIV_W'(20);
            r_long_press   <= TIME_W'(1000);
            r_long_repeat  <= TIME_W'(500);
            r_multi_break  <= TIME_W'(250);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                C_REG_VALUE_MASK:   r_value_mask   <= i_cfg_wdata[PIN_W-1:0];
                C_REG_ACTIVE_VALUE: r_active_value <= i_cfg_wdata[PIN_W-1:0];
                C_REG_STEP_PERIOD:  r_step_period  <= i_cfg_wdata[DIV_W-1:0];
                C_REG_LONG_PRESS:   r_long_press   <= i_cfg_wdata;
                C_REG_LONG_REPEAT:  r_long_repeat  <= i_cfg_wdata;
                C_REG_MULTI_BREAK:  r_multi_break  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Mask the pins and update the durations and the step divider
    always_comb begin
        masked_value = s_axis_tdata & C_PIN_MASK & r_value_mask;
        pressed      = (masked_value == r_active_value);
        if (pressed) begin
            n_pressed_time  = (r_pressed_time < C_TIME_SAT)
                            ? r_pressed_time + TIME_W'(1) : r_pressed_time;
            n_released_time = '0;
        end else begin
            n_pressed_time  = '0;
            n_released_time = (r_released_time < C_TIME_SAT)
                            ? r_released_time + TIME_W'(1) : r_released_time;
        end
        div_inc   = r_divider + DIV_W'(1);
        n_divider = (div_inc >= r_step_period) ? '0 : div_inc;
    end

    assign tick.step          = accept;
    assign tick.run           = (div_inc >= r_step_period);
    assign tick.pressed       = pressed;
    assign tick.changed       = (masked_value != r_prev_value);
    assign tick.pressed_time  = n_pressed_time;
    assign tick.released_time = n_released_time;

    assign thresh.long_press  = r_long_press;
    assign thresh.long_repeat = r_long_repeat;
    assign thresh.multi_break = r_multi_break;

    bed_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_thresh (thresh),
        .o_result (result)
    );

    // Hold tick state, advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_time  <= '0;
            r_released_time <= '0;
            r_prev_value    <= '0;
            r_divider       <= '0;
        end else if (accept) begin
            r_pressed_time  <= n_pressed_time;
            r_released_time <= n_released_time;
            r_prev_value    <= masked_value;
            r_divider       <= n_divider;
        end
    end

    // Result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (pop && r_skd_valid) begin
            r_out_valid <= 1'b1;
            r_skd_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            r_out_valid <= accept;
        end else if (accept) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skd_valid) begin
            r_out_data <= r_skd_data;
        end else if ((pop || !r_out_valid) && accept) begin
            r_out_data <= result;
        end
        if (accept && r_out_valid && !pop) begin
            r_skd_data <= result;
        end
    end

    assign s_axis_tready = !r_skd_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data.state, r_out_data.arg, r_out_data.code};

endmodule

>>> sim/tb_top.sv
// Testbench for the button event detector: directed and random tick streams
// checked against an in-bench predictor of the press machine.
// Depends on bed_pkg and button_event_detector.
`timescale 1ns / 1ps

module tb_top;
    import bed_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] pin_value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;    // [2:0] event_code, [18:3] event_arg,
                                        // [21:19] button_state, [23:22] zero

    // Configuration as the predictor sees it
    logic [7:0]  cfg_mask;
    logic [7:0]  cfg_active;
    logic [7:0]  cfg_period;
    logic [15:0] cfg_long;
    logic [15:0] cfg_repeat;
    logic [15:0] cfg_break;

    // Predictor state
    t_state      btn_state;
    logic [15:0] held_ticks;
    logic [15:0] free_ticks;
    logic [15:0] click_count;
    logic [15:0] repeat_mark;
    logic [7:0]  last_masked;
    logic [7:0]  div_count;
    logic        change_seen;

    t_result     pending_events[$];
    int          mismatch_count = 0;
    bit          idling_en = 1'b1;

    button_event_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random while idling is enabled
    always @(posedge i_clk) begin
        m_axis_tready <= !idling_en || ($urandom_range(99) >= 30);
    end

    // Advance the predictor by one tick and return the event it gives
    function automatic t_result next_button_event(input logic [7:0] pin);
        t_result     res;
        logic [7:0]  masked;
        logic        pressed;
        logic [15:0] gap;
        masked    = pin & C_PIN_MASK & cfg_mask;
        pressed   = (masked == cfg_active);
        res.code  = EV_NONE;
        res.arg   = '0;
        if (masked != last_masked) begin
            change_seen = 1'b1;
            last_masked = masked;
        end
        // Duration counters saturate
        if (pressed) begin
            if (held_ticks < C_TIME_SAT) held_ticks = held_ticks + 16'd1;
            free_ticks = '0;
        end else begin
            held_ticks = '0;
            if (free_ticks < C_TIME_SAT) free_ticks = free_ticks + 16'd1;
        end
        div_count = div_count + 8'd1;
        if (div_count >= cfg_period) begin
            div_count = '0;
            case (btn_state)
                ST_RELEASED: begin
                    if (pressed) begin
                        btn_state = ST_FIRST_PRESS;
                        res.code  = EV_PRESS;
                    end
                end
                ST_FIRST_PRESS: begin
                    if (!pressed) begin
                        btn_state = ST_FIRST_UP;
                        res.code  = EV_UP;
                    end else if (held_ticks >= cfg_long) begin
                        btn_state   = ST_LONG;
                        repeat_mark = '0;
                    end
                end
                ST_LONG: begin
                    if (!pressed) begin
                        btn_state = ST_RELEASED;
                        res.code  = EV_LONG_UP;
                    end else begin
                        // Distance either way from the last repeat
                        gap = (held_ticks >= repeat_mark) ? held_ticks - repeat_mark
                                                          : repeat_mark - held_ticks;
                        if (gap >= cfg_repeat) begin
                            repeat_mark = held_ticks;
                            res.code    = EV_LONG_PRESS;
                            res.arg     = held_ticks;
                        end
                    end
                end
                ST_FIRST_UP: begin
                    if (pressed) begin
                        btn_state   = ST_MULTI;
                        click_count = 16'd1;
                    end else if (free_ticks >= cfg_break) begin
                        btn_state = ST_RELEASED;
                    end
                end
                ST_MULTI: begin
                    if (change_seen) begin
                        change_seen = 1'b0;
                        if (pressed) begin
                            if (click_count < C_COUNT_SAT) click_count = click_count + 16'd1;
                            res.code = EV_MULTI_PRESS;
                        end else begin
                            res.code = EV_MULTI_UP;
                        end
                        res.arg = click_count;
                    end else if (held_ticks >= cfg_long) begin
                        btn_state   = ST_LONG;
                        repeat_mark = '0;
                    end else if (free_ticks >= cfg_break) begin
                        btn_state = ST_RELEASED;
                    end
                end
                default: ;
            endcase
        end
        res.state = btn_state;
        return res;
    endfunction

    // Random pin bits that carry the active pattern on the masked bits
    function automatic logic [7:0] pressed_pin();
        logic [7:0] pin;
        pin = 8'($urandom);
        return (pin & ~cfg_mask) | (cfg_active & cfg_mask);
    endfunction

    // Random pin bits whose masked value differs from the active pattern, unless mask and pattern are both zero
    function automatic logic [7:0] released_pin();
        logic [7:0] pin;
        pin = 8'($urandom);
        if ((pin & cfg_mask) == cfg_active) pin = pin ^ cfg_mask;
        return pin;
    endfunction

    function automatic logic [15:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 10) return 16'd60000;
        if (r < 14) return 16'($urandom_range(41, 60000));
        return 16'($urandom_range(1, 40));
    endfunction

    // Offer one tick, hold until the transfer, then log its expected event
    task automatic send_tick(input logic [7:0] pin);
        while (idling_en && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pin;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_events.push_back(next_button_event(pin));
    endtask

    task automatic send_run(input logic level, input int len);
        repeat (len) send_tick(level ? pressed_pin() : released_pin());
    endtask

    // Drop valid and hold until every expected event has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            C_REG_VALUE_MASK:   cfg_mask   = val[7:0];
            C_REG_ACTIVE_VALUE: cfg_active = val[7:0];
            C_REG_STEP_PERIOD:  cfg_period = val[7:0];
            C_REG_LONG_PRESS:   cfg_long   = val;
            C_REG_LONG_REPEAT:  cfg_repeat = val;
            C_REG_MULTI_BREAK:  cfg_break  = val;
            default: ;
        endcase
    endtask

    task automatic write_regs(input logic [7:0] mask, input logic [7:0] active,
                              input logic [7:0] period, input logic [15:0] lp,
                              input logic [15:0] lr, input logic [15:0] mb);
        write_reg(C_REG_VALUE_MASK, 16'(mask));
        write_reg(C_REG_ACTIVE_VALUE, 16'(active));
        write_reg(C_REG_STEP_PERIOD, 16'(period));
        write_reg(C_REG_LONG_PRESS, lp);
        write_reg(C_REG_LONG_REPEAT, lr);
        write_reg(C_REG_MULTI_BREAK, mb);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset configuration: a held low bit 0 gives a press on the twentieth tick
    task automatic test_reset_defaults();
        send_tick(8'h00);
        send_tick(8'hFE);
        send_run(1'b1, 18);
        send_tick(8'hFF);
        send_tick(8'h01);
        send_run(1'b0, 2);
        wait_for_results();
    endtask

    // Machine on every tick with short thresholds: every event kind
    task automatic test_event_kinds();
        write_regs(8'h03, 8'h02, 8'd0, 16'd4, 16'd2, 16'd3);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 4);
        send_run(1'b1, 7);
        send_run(1'b0, 2);
        wait_for_results();
    endtask

    // Zero thresholds are met at once
    task automatic test_zero_thresholds();
        write_regs(8'hFF, 8'h00, 8'd1, 16'd0, 16'd0, 16'd0);
        send_run(1'b1, 3);
        send_run(1'b0, 3);
        send_run(1'b1, 3);
        send_run(1'b0, 3);
        wait_for_results();
    endtask

    // Empty mask, active pattern outside the mask, full mask
    task automatic test_mask_extremes();
        write_regs(8'h00, 8'h00, 8'd1, 16'd2, 16'd1, 16'd2);
        send_tick(8'hFF);
        send_tick(8'h00);
        repeat (4) send_tick(8'($urandom));
        wait_for_results();
        write_regs(8'h0F, 8'hF0, 8'd1, 16'd2, 16'd1, 16'd2);
        repeat (6) send_tick(8'($urandom));
        wait_for_results();
        write_regs(8'hFF, 8'hFF, 8'd1, 16'd2, 16'd1, 16'd2);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h7F);
        wait_for_results();
    endtask

    // Longest period, then a lower period while the divider is past it
    task automatic test_period_change();
        write_regs(8'h01, 8'h01, 8'd255, 16'd60000, 16'd1, 16'd1);
        send_run(1'b1, 150);
        send_run(1'b0, 150);
        wait_for_results();
        write_regs(8'h01, 8'h01, 8'd10, 16'd60000, 16'd1, 16'd1);
        send_run(1'b1, 12);
        wait_for_results();
    endtask

    // Press and release runs of eight ticks, without idling on either side
    task automatic test_back_to_back();
        int i;
        idling_en = 1'b0;
        write_regs(8'h01, 8'h00, 8'd0, 16'd6, 16'd3, 16'd5);
        for (i = 0; i < 200; i++) send_tick(i[3] ? released_pin() : pressed_pin());
        wait_for_results();
        idling_en = 1'b1;
    endtask

    // Random settings; mostly alternating press and release runs, some noise
    task automatic test_random_runs();
        int          phase;
        int          sent;
        int          len;
        int          kind;
        logic        level;
        logic        paused;
        logic [7:0]  m;
        logic [7:0]  a;
        logic [7:0]  p;
        level  = 1'b0;
        paused = 1'b0;
        for (phase = 0; phase < 8; phase++) begin
            kind = $urandom_range(99);
            m = (kind < 10) ? 8'hFF : (kind < 20) ? 8'h01 : (kind < 25) ? 8'h00
                                    : 8'($urandom_range(1, 255));
            a = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom) & m;
            kind = $urandom_range(99);
            p = (kind < 8) ? 8'd0 : (kind < 14) ? 8'd255 : (kind < 20)
                ? 8'($urandom_range(5, 254)) : 8'($urandom_range(1, 4));
            write_regs(m, a, p, pick_threshold(), pick_threshold(), pick_threshold());
            sent = 0;
            while (sent < 90) begin
                // Let the result side catch up fully once, mid-phase
                if (phase == 4 && sent >= 45 && !paused) begin
                    wait_for_results();
                    paused = 1'b1;
                end
                kind = $urandom_range(99);
                if (kind < 20) begin
                    len = $urandom_range(1, 8);
                    repeat (len) send_tick(8'($urandom));
                end else begin
                    if (kind >= 30) level = ~level;
                    len = $urandom_range(1, 4) * ((p == 8'd0) ? 1 : int'(p))
                        + $urandom_range(0, (kind < 45) ? 60 : 5);
                    send_run(level, len);
                end
                sent += len;
            end
            wait_for_results();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_mask      = 8'd1;
        cfg_active    = 8'd0;
        cfg_period    = 8'd20;
        cfg_long      = 16'd1000;
        cfg_repeat    = 16'd500;
        cfg_break     = 16'd250;
        btn_state     = ST_RELEASED;
        held_ticks    = '0;
        free_ticks    = '0;
        click_count   = '0;
        repeat_mark   = '0;
        last_masked   = '0;
        div_count     = '0;
        change_seen   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_event_kinds();
        test_zero_thresholds();
        test_mask_extremes();
        test_period_change();
        test_back_to_back();
        test_random_runs();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Compare each result transfer with the oldest expected event
    always @(posedge i_clk) begin : check_events
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: tdata %h", m_axis_tdata);
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tdata[2:0] !== want.code || m_axis_tdata[18:3] !== want.arg ||
                    m_axis_tdata[21:19] !== want.state) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("event mismatch: expected code %0d arg %0d state %0d, got %0d %0d %0d",
                                 want.code, want.arg, want.state, m_axis_tdata[2:0],
                                 m_axis_tdata[18:3], m_axis_tdata[21:19]);
                end
            end
        end
    end

    // Give up well after the slowest passing run
    initial begin
        #(64'd2_000_000 * 12);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> button_event_detector.f
rtl/bed_pkg.sv
rtl/bed_fsm.sv
rtl/button_event_detector.sv
sim/tb_top.sv
